// ----- design/owbm_pkg.sv -----
// Shared types, register map, reset values and CRC helper for the 1-Wire bus master.
`default_nettype none

package owbm_pkg;

  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 32;

  typedef enum logic [2:0] {
    REG_RESET_LOW       = 3'd0,
    REG_PRESENCE_SAMPLE = 3'd1,
    REG_RESET_TAIL      = 3'd2,
    REG_SHORT_LOW       = 3'd3,
    REG_LONG_LOW        = 3'd4,
    REG_READ_SAMPLE     = 3'd5,
    REG_SLOT_LENGTH     = 3'd6
  } reg_idx_e;

  localparam logic [9:0] ResetLowRst       = 10'd480;
  localparam logic [9:0] PresenceSampleRst = 10'd70;
  localparam logic [9:0] ResetTailRst      = 10'd410;
  localparam logic [7:0] ShortLowRst       = 8'd6;
  localparam logic [7:0] LongLowRst        = 8'd60;
  localparam logic [7:0] ReadSampleRst     = 8'd15;
  localparam logic [7:0] SlotLengthRst     = 8'd70;

  localparam logic [7:0] CrcPoly = 8'h8c;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_RESET = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_READ  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_RST_LOW  = 3'd1,
    PH_RST_WAIT = 3'd2,
    PH_RST_TAIL = 3'd3,
    PH_WRITE    = 3'd4,
    PH_READ     = 3'd5
  } phase_e;

  typedef struct packed {
    logic [9:0] reset_low_us;
    logic [9:0] presence_sample_us;
    logic [9:0] reset_tail_us;
    logic [7:0] short_low_us;
    logic [7:0] long_low_us;
    logic [7:0] read_sample_us;
    logic [7:0] slot_length_us;
  } cfg_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
    logic [7:0] crc_value;
    logic       rejected;
  } res_t;

  function automatic logic [9:0] max1_10(input logic [9:0] v);
    return (v == 10'd0) ? 10'd1 : v;
  endfunction

  function automatic logic [7:0] max1_8(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] crc;
    logic       mix;
    crc = crc_in;
    for (int i = 0; i < 8; i++) begin
      mix = crc[0] ^ data[i];
      crc = {1'b0, crc[7:1]};
      if (mix) begin
        crc = crc ^ CrcPoly;
      end
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

// ----- design/owbm_regs.sv -----
// APB-style configuration register file for the 1-Wire bus master timing.
`default_nettype none

module owbm_regs
  import owbm_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [AddrWidth-1:0] paddr,
  input  wire logic [DataWidth-1:0] pwdata,
  output logic      [DataWidth-1:0] prdata,
  output logic                      pready,
  output cfg_t                      cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[AddrWidth-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_us       <= ResetLowRst;
      cfg_q.presence_sample_us <= PresenceSampleRst;
      cfg_q.reset_tail_us      <= ResetTailRst;
      cfg_q.short_low_us       <= ShortLowRst;
      cfg_q.long_low_us        <= LongLowRst;
      cfg_q.read_sample_us     <= ReadSampleRst;
      cfg_q.slot_length_us     <= SlotLengthRst;
    end else if (wr_en) begin
      case (idx)
        REG_RESET_LOW:       cfg_q.reset_low_us       <= pwdata[9:0];
        REG_PRESENCE_SAMPLE: cfg_q.presence_sample_us <= pwdata[9:0];
        REG_RESET_TAIL:      cfg_q.reset_tail_us      <= pwdata[9:0];
        REG_SHORT_LOW:       cfg_q.short_low_us       <= pwdata[7:0];
        REG_LONG_LOW:        cfg_q.long_low_us        <= pwdata[7:0];
        REG_READ_SAMPLE:     cfg_q.read_sample_us     <= pwdata[7:0];
        REG_SLOT_LENGTH:     cfg_q.slot_length_us     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RESET_LOW:       prdata = {22'd0, cfg_q.reset_low_us};
      REG_PRESENCE_SAMPLE: prdata = {22'd0, cfg_q.presence_sample_us};
      REG_RESET_TAIL:      prdata = {22'd0, cfg_q.reset_tail_us};
      REG_SHORT_LOW:       prdata = {24'd0, cfg_q.short_low_us};
      REG_LONG_LOW:        prdata = {24'd0, cfg_q.long_low_us};
      REG_READ_SAMPLE:     prdata = {24'd0, cfg_q.read_sample_us};
      REG_SLOT_LENGTH:     prdata = {24'd0, cfg_q.slot_length_us};
      default:             prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- design/owbm_fsm.sv -----
// Bus timing state machine, bit shifter and CRC-8 accumulator of the 1-Wire bus master.
`default_nettype none

module owbm_fsm
  import owbm_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  cfg_t            cfg_i,
  input  wire logic       accept_i,
  input  wire logic [1:0] kind_i,
  input  wire logic [7:0] write_byte_i,
  input  wire logic       line_level_i,
  output res_t            res_o
);

  phase_e     phase_q, phase_d;
  logic [9:0] tick_q, tick_d;
  logic [2:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] crc_q, crc_d;
  logic       pres_q, pres_d;
  logic       drive_q, drive_d;

  kind_e      kind;
  logic       busy;
  logic       is_tick;
  logic       cmd_start;
  logic [9:0] tick_inc;
  logic       rl_end, wait_end, tail_end, slot_end, last_bit;
  logic [7:0] slot8, smp8, smp_pos, low_time;
  logic       smp_hit, low_end;
  logic [7:0] shift_smp;
  logic       done;
  logic [7:0] rdata;

  assign kind      = kind_e'(kind_i);
  assign is_tick   = (kind == KIND_TICK);
  assign cmd_start = accept_i & ~is_tick & ~busy;
  assign tick_inc  = tick_q + 10'd1;
  assign last_bit  = (bit_q == 3'd7);

  always_comb begin
    case (phase_q)
      PH_RST_LOW, PH_RST_WAIT, PH_RST_TAIL, PH_WRITE, PH_READ: busy = 1'b1;
      default: busy = 1'b0;
    endcase
  end

  assign rl_end   = tick_inc >= max1_10(cfg_i.reset_low_us);
  assign wait_end = tick_inc >= max1_10(cfg_i.presence_sample_us);
  assign tail_end = tick_inc >= max1_10(cfg_i.reset_tail_us);
  assign slot8    = max1_8(cfg_i.slot_length_us);
  assign slot_end = tick_inc >= {2'd0, slot8};
  assign smp8     = max1_8(cfg_i.read_sample_us);
  assign smp_pos  = (smp8 > slot8) ? slot8 : smp8;
  assign smp_hit  = (phase_q == PH_READ) && (tick_inc == {2'd0, smp_pos});
  assign low_time = ((phase_q == PH_WRITE) && !shift_q[0]) ? max1_8(cfg_i.long_low_us)
                                                           : max1_8(cfg_i.short_low_us);
  assign low_end  = tick_inc >= {2'd0, low_time};
  assign shift_smp = smp_hit ? {line_level_i, shift_q[7:1]} : shift_q;

  always_comb begin
    phase_d = phase_q;
    if (cmd_start) begin
      case (kind)
        KIND_RESET: phase_d = PH_RST_LOW;
        KIND_WRITE: phase_d = PH_WRITE;
        KIND_READ:  phase_d = PH_READ;
        default:    phase_d = phase_q;
      endcase
    end else if (accept_i && is_tick) begin
      case (phase_q)
        PH_RST_LOW:  if (rl_end) phase_d = PH_RST_WAIT;
        PH_RST_WAIT: if (wait_end) phase_d = PH_RST_TAIL;
        PH_RST_TAIL: if (tail_end) phase_d = PH_IDLE;
        PH_WRITE, PH_READ: if (slot_end && last_bit) phase_d = PH_IDLE;
        default: phase_d = phase_q;
      endcase
    end
  end

  always_comb begin
    tick_d  = tick_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    crc_d   = crc_q;
    pres_d  = pres_q;
    drive_d = drive_q;
    done    = 1'b0;
    rdata   = 8'd0;
    if (cmd_start) begin
      tick_d  = '0;
      bit_d   = '0;
      drive_d = 1'b1;
      case (kind)
        KIND_RESET: begin
          crc_d  = '0;
          pres_d = 1'b0;
        end
        KIND_WRITE: shift_d = write_byte_i;
        KIND_READ:  shift_d = '0;
        default: ;
      endcase
    end else if (accept_i && is_tick && busy) begin
      tick_d = tick_inc;
      case (phase_q)
        PH_RST_LOW: begin
          if (rl_end) begin
            drive_d = 1'b0;
            tick_d  = '0;
          end
        end
        PH_RST_WAIT: begin
          if (wait_end) begin
            pres_d = ~line_level_i;
            tick_d = '0;
          end
        end
        PH_RST_TAIL: begin
          if (tail_end) begin
            tick_d = '0;
            done   = 1'b1;
          end
        end
        PH_WRITE, PH_READ: begin
          if (low_end) drive_d = 1'b0;
          shift_d = shift_smp;
          if (slot_end) begin
            drive_d = 1'b0;
            tick_d  = '0;
            if (phase_q == PH_WRITE) shift_d = {1'b0, shift_q[7:1]};
            if (last_bit) begin
              bit_d = '0;
              done  = 1'b1;
              if (phase_q == PH_READ) begin
                rdata = shift_smp;
                crc_d = crc8_byte(crc_q, shift_smp);
              end
            end else begin
              bit_d   = bit_q + 3'd1;
              drive_d = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      crc_q   <= '0;
      pres_q  <= 1'b0;
      drive_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      crc_q   <= crc_d;
      pres_q  <= pres_d;
      drive_q <= drive_d;
    end
  end

  always_comb begin
    res_o.drive_low = drive_d;
    case (phase_d)
      PH_RST_LOW, PH_RST_WAIT, PH_RST_TAIL, PH_WRITE, PH_READ: res_o.busy_res = 1'b1;
      default: res_o.busy_res = 1'b0;
    endcase
    res_o.done_res  = done;
    res_o.presence  = pres_d;
    res_o.read_data = rdata;
    res_o.crc_value = crc_d;
    res_o.rejected  = accept_i & ~is_tick & busy;
  end

endmodule

`default_nettype wire

// ----- design/one_wire_bus_master_core.sv -----
// Top level of the 1-Wire bus master with running CRC-8 over bytes read.
`default_nettype none

// Each transaction on the input channel is one microsecond tick carrying the
// sampled line level, or a command (reset with presence detect, write byte,
// read byte). Every input transaction yields exactly one result transaction,
// delivered through an output register. One input is taken per clock
// cycle; the input stalls only while a result is held in the output register
// and the output is stalled. Timing registers are written over the APB port
// at byte address 4*index and should only be changed while the block is idle.
module one_wire_bus_master_core
  import owbm_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [1:0]           kind_i,
  input  wire logic [7:0]           write_byte_i,
  input  wire logic                 line_level_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      drive_low_o,
  output logic                      busy_res_o,
  output logic                      done_res_o,
  output logic                      presence_o,
  output logic      [7:0]           read_data_o,
  output logic      [7:0]           crc_value_o,
  output logic                      rejected_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [AddrWidth-1:0] paddr,
  input  wire logic [DataWidth-1:0] pwdata,
  output logic      [DataWidth-1:0] prdata,
  output logic                      pready
);

  cfg_t cfg;
  res_t res_d, res_q;
  logic accept;
  logic out_valid_q, out_valid_d;

  owbm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  owbm_fsm u_fsm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .accept_i     (accept),
    .kind_i       (kind_i),
    .write_byte_i (write_byte_i),
    .line_level_i (line_level_i),
    .res_o        (res_d)
  );

  assign out_valid_d = accept | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_low_o = res_q.drive_low;
  assign busy_res_o  = res_q.busy_res;
  assign done_res_o  = res_q.done_res;
  assign presence_o  = res_q.presence;
  assign read_data_o = res_q.read_data;
  assign crc_value_o = res_q.crc_value;
  assign rejected_o  = res_q.rejected;

endmodule

`default_nettype wire
